>>> hw/rtl/qmr_pkg.sv
package qmr_pkg;

  localparam int HAM_STAGES  = 5;
  localparam int PIPE_STAGES = 2 * HAM_STAGES;

  typedef enum logic {
    CMD_PRODUCT = 1'b0,
    CMD_ROTATE  = 1'b1
  } cmd_t;

  typedef logic [1:0] comp_t;

  localparam comp_t COMP_W = 2'd0;
  localparam comp_t COMP_X = 2'd1;
  localparam comp_t COMP_Y = 2'd2;
  localparam comp_t COMP_Z = 2'd3;

  // right-hand component of each hamilton term, by result component and term
  localparam comp_t Q_SEL [4][4] = '{
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_X, COMP_W, COMP_Z, COMP_Y},
    '{COMP_Y, COMP_Z, COMP_W, COMP_X},
    '{COMP_Z, COMP_Y, COMP_X, COMP_W}
  };

  // subtract flags for the three left-to-right accumulations
  localparam logic SUB_OP [4][3] = '{
    '{1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0}
  };

endpackage

>>> hw/rtl/qmr_if.sv
interface qmr_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [WORD_BITS-1:0] a_w;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] b_w;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;

  modport source (
    output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    input  ready
  );

  modport sink (
    input  valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    output ready
  );
endinterface

interface qmr_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_w;
  logic signed [WORD_BITS-1:0] res_x;
  logic signed [WORD_BITS-1:0] res_y;
  logic signed [WORD_BITS-1:0] res_z;

  modport source (
    output valid, res_w, res_x, res_y, res_z,
    input  ready
  );

  modport sink (
    input  valid, res_w, res_x, res_y, res_z,
    output ready
  );
endinterface

>>> hw/rtl/qmr_hamilton.sv
module qmr_hamilton #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int Q_BITS    = 32
) (
  input  logic                                clk,
  input  logic [qmr_pkg::HAM_STAGES-1:0]      en,
  input  logic signed [WORD_BITS-1:0]         p [4],
  input  logic signed [Q_BITS-1:0]            q [4],
  output logic signed [WORD_BITS-1:0]         r [4]
);
  import qmr_pkg::*;

  localparam int PW = WORD_BITS + Q_BITS;
  localparam logic signed [PW-1:0] MAXP = {{(Q_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [PW-1:0] MINP = {{(Q_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  function automatic logic signed [WORD_BITS-1:0] sat_prod(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = v >>> FRAC_BITS;
    if (s > MAXP) return WMAX;
    if (s < MINP) return WMIN;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [WORD_BITS-1:0] add_sat(
    input logic signed [WORD_BITS-1:0] x,
    input logic signed [WORD_BITS-1:0] y,
    input logic                        sub
  );
    logic signed [WORD_BITS:0] s;
    if (sub) begin
      s = {x[WORD_BITS-1], x} - {y[WORD_BITS-1], y};
    end else begin
      s = {x[WORD_BITS-1], x} + {y[WORD_BITS-1], y};
    end
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return s[WORD_BITS-1:0];
  endfunction

  logic signed [PW-1:0]        prod_r [4][4];
  logic signed [WORD_BITS-1:0] term_r [4][4];
  logic signed [WORD_BITS-1:0] acc3_r [4];
  logic signed [WORD_BITS-1:0] t2_r   [4];
  logic signed [WORD_BITS-1:0] t3a_r  [4];
  logic signed [WORD_BITS-1:0] acc4_r [4];
  logic signed [WORD_BITS-1:0] t3b_r  [4];
  logic signed [WORD_BITS-1:0] acc5_r [4];

  // partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[c][k] <= PW'(p[k]) * PW'(q[Q_SEL[c][k]]);
        end
      end
    end
  end

  // fraction shift and saturation
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          term_r[c][k] <= sat_prod(prod_r[c][k]);
        end
      end
    end
  end

  // saturating accumulation, one add per stage
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        acc3_r[c] <= add_sat(term_r[c][0], term_r[c][1], SUB_OP[c][0]);
        t2_r[c]   <= term_r[c][2];
        t3a_r[c]  <= term_r[c][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 4; c++) begin
        acc4_r[c] <= add_sat(acc3_r[c], t2_r[c], SUB_OP[c][1]);
        t3b_r[c]  <= t3a_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 4; c++) begin
        acc5_r[c] <= add_sat(acc4_r[c], t3b_r[c], SUB_OP[c][2]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      r[c] = acc5_r[c];
    end
  end

endmodule

>>> hw/rtl/quaternion_multiply_rotate.sv
// Fixed-point quaternion unit on signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS words. Command 0
// returns the Hamilton product a*b; command 1 rotates the vector (b_x, b_y, b_z) by a as
// a*v*conj(a) and returns it with res_w zero. Every product is floored after the fraction
// shift and saturated, every partial sum saturates. The block takes one beat per cycle while
// in_ch.ready is high, and each result passes through two five-stage Hamilton units in series
// (multiply, shift and saturate, three accumulate stages), the second used by rotations and
// the first result carried alongside it for products. A stalled output holds the last stage
// while empty stages upstream keep filling.
module quaternion_multiply_rotate #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic     clk,
  input logic     rst_n,
  qmr_in_if.sink  in_ch,
  qmr_out_if.source out_ch
);
  import qmr_pkg::*;

  localparam int L = PIPE_STAGES;
  localparam int H = HAM_STAGES;

  logic [L-1:0]                v_r;
  logic [L-1:0]                en;
  logic                        cmd_r   [L];
  logic signed [WORD_BITS-1:0] a_dly_r [H][4];
  logic signed [WORD_BITS-1:0] byp_r   [H][4];

  logic signed [WORD_BITS-1:0] p1     [4];
  logic signed [WORD_BITS-1:0] q1     [4];
  logic signed [WORD_BITS-1:0] r1     [4];
  logic signed [WORD_BITS:0]   conj_a [4];
  logic signed [WORD_BITS-1:0] r2     [4];

  // stage advances when empty or when the next one advances
  always_comb begin
    en[L-1] = !v_r[L-1] || out_ch.ready;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < L; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) cmd_r[0] <= in_ch.command;
    for (int k = 1; k < L; k++) begin
      if (en[k]) cmd_r[k] <= cmd_r[k-1];
    end
  end

  always_comb begin
    p1[0] = in_ch.a_w;
    p1[1] = in_ch.a_x;
    p1[2] = in_ch.a_y;
    p1[3] = in_ch.a_z;
    q1[0] = (in_ch.command == CMD_ROTATE) ? '0 : in_ch.b_w;
    q1[1] = in_ch.b_x;
    q1[2] = in_ch.b_y;
    q1[3] = in_ch.b_z;
  end

  // a travels beside the first unit for the conjugate
  always_ff @(posedge clk) begin
    if (en[0]) a_dly_r[0] <= p1;
    for (int k = 1; k < H; k++) begin
      if (en[k]) a_dly_r[k] <= a_dly_r[k-1];
    end
  end

  always_comb begin
    conj_a[0] = (WORD_BITS + 1)'(a_dly_r[H-1][0]);
    for (int i = 1; i < 4; i++) begin
      conj_a[i] = -((WORD_BITS + 1)'(a_dly_r[H-1][i]));
    end
  end

  qmr_hamilton #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .Q_BITS    (WORD_BITS)
  ) u_ham_first (
    .clk (clk),
    .en  (en[H-1:0]),
    .p   (p1),
    .q   (q1),
    .r   (r1)
  );

  qmr_hamilton #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .Q_BITS    (WORD_BITS + 1)
  ) u_ham_second (
    .clk (clk),
    .en  (en[L-1:H]),
    .p   (r1),
    .q   (conj_a),
    .r   (r2)
  );

  // product result rides beside the second unit
  always_ff @(posedge clk) begin
    if (en[H]) byp_r[0] <= r1;
    for (int k = 1; k < H; k++) begin
      if (en[H+k]) byp_r[k] <= byp_r[k-1];
    end
  end

  assign out_ch.valid = v_r[L-1];
  assign out_ch.res_w = (cmd_r[L-1] == CMD_ROTATE) ? '0    : byp_r[H-1][0];
  assign out_ch.res_x = (cmd_r[L-1] == CMD_ROTATE) ? r2[1] : byp_r[H-1][1];
  assign out_ch.res_y = (cmd_r[L-1] == CMD_ROTATE) ? r2[2] : byp_r[H-1][2];
  assign out_ch.res_z = (cmd_r[L-1] == CMD_ROTATE) ? r2[3] : byp_r[H-1][3];

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

  a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &v_r)
    else $error("input stalled with an empty stage in the pipeline");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while the output drains");

  a_stall_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] && !out_ch.ready |=> v_r[L-1] && $stable(byp_r[H-1][1]) && $stable(r2[1]))
    else $error("last stage changed while stalled");

endmodule

>>> sim/quaternion_multiply_rotate_tb.sv
`timescale 1ns / 1ps

module quaternion_multiply_rotate_tb;
  import qmr_pkg::*;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 30;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t NEG_ONE = -32'sh0001_0000;
  localparam word_t COS45 = 32'sh0000_b505;

  typedef struct {
    cmd_t  command;
    word_t a_w, a_x, a_y, a_z;
    word_t b_w, b_x, b_y, b_z;
  } quat_op_t;

  typedef struct {
    word_t w, x, y, z;
  } quat_res_t;

  typedef struct {
    longint w, x, y, z;
  } quat_wide_t;

  logic clk = 1'b0;
  logic rst_n;

  qmr_in_if #(.WORD_BITS(WORD_BITS)) in_ch ();
  qmr_out_if #(.WORD_BITS(WORD_BITS)) out_ch ();

  quaternion_multiply_rotate #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  quat_res_t expected_res[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_left = 0;
  int        quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fixed-point model of the block
  function automatic longint sat_word(longint v);
    if (v > longint'(W_MAX)) return longint'(W_MAX);
    if (v < longint'(W_MIN)) return longint'(W_MIN);
    return v;
  endfunction

  function automatic longint fx_mul(longint p, longint q);
    longint prod;
    prod = p * q;
    return sat_word(prod >>> FRAC_BITS);
  endfunction

  function automatic quat_wide_t hamilton(quat_wide_t p, quat_wide_t q);
    quat_wide_t r;
    r.w = sat_word(sat_word(sat_word(fx_mul(p.w, q.w) - fx_mul(p.x, q.x))
          - fx_mul(p.y, q.y)) - fx_mul(p.z, q.z));
    r.x = sat_word(sat_word(sat_word(fx_mul(p.w, q.x) + fx_mul(p.x, q.w))
          + fx_mul(p.y, q.z)) - fx_mul(p.z, q.y));
    r.y = sat_word(sat_word(sat_word(fx_mul(p.w, q.y) - fx_mul(p.x, q.z))
          + fx_mul(p.y, q.w)) + fx_mul(p.z, q.x));
    r.z = sat_word(sat_word(sat_word(fx_mul(p.w, q.z) + fx_mul(p.x, q.y))
          - fx_mul(p.y, q.x)) + fx_mul(p.z, q.w));
    return r;
  endfunction

  function automatic quat_res_t multiply_or_rotate(quat_op_t op);
    quat_wide_t a, b, conj_a, r;
    quat_res_t  res;
    a = '{longint'(op.a_w), longint'(op.a_x), longint'(op.a_y), longint'(op.a_z)};
    b = '{longint'(op.b_w), longint'(op.b_x), longint'(op.b_y), longint'(op.b_z)};
    if (op.command == CMD_PRODUCT) begin
      r = hamilton(a, b);
    end else begin
      b.w = 0;
      // negating the most negative word stays exact here
      conj_a = '{a.w, -a.x, -a.y, -a.z};
      r = hamilton(hamilton(a, b), conj_a);
      r.w = 0;
    end
    res.w = word_t'(r.w);
    res.x = word_t'(r.x);
    res.y = word_t'(r.y);
    res.z = word_t'(r.z);
    return res;
  endfunction

  // stimulus helpers
  function automatic quat_op_t make_op(cmd_t cmd, word_t aw, word_t ax, word_t ay, word_t az,
                                       word_t bw, word_t bx, word_t by, word_t bz);
    quat_op_t op;
    op = '{cmd, aw, ax, ay, az, bw, bx, by, bz};
    return op;
  endfunction

  function automatic word_t rand_word();
    word_t v;
    case ($urandom_range(7))
      0, 1: v = word_t'($urandom);
      2, 3, 4, 5: v = word_t'($urandom_range(1 << 19)) - word_t'(1 << 18);
      6: begin
        case ($urandom_range(4))
          0: v = W_MIN;
          1: v = W_MAX;
          2: v = '0;
          3: v = ONE;
          default: v = NEG_ONE;
        endcase
      end
      default: v = word_t'($urandom) >>> $urandom_range(24, 8);
    endcase
    return v;
  endfunction

  function automatic quat_op_t rand_op();
    return make_op(cmd_t'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  task automatic send_op(input quat_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= op.command;
    in_ch.a_w     <= op.a_w;
    in_ch.a_x     <= op.a_x;
    in_ch.a_y     <= op.a_y;
    in_ch.a_z     <= op.a_z;
    in_ch.b_w     <= op.b_w;
    in_ch.b_x     <= op.b_x;
    in_ch.b_y     <= op.b_y;
    in_ch.b_z     <= op.b_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_res.push_back(multiply_or_rotate(op));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_op(rand_op());
    wait_drained();
  endtask

  // tests
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(make_op(CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(CMD_PRODUCT, ONE, 0, 0, 0, 32'sh0002_8000, -32'sh0001_4000,
                    32'sh0000_0123, -32'sh0007_0000));
    send_op(make_op(CMD_PRODUCT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    send_op(make_op(CMD_PRODUCT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    send_op(make_op(CMD_PRODUCT, W_MAX, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN));
    send_op(make_op(CMD_PRODUCT, W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX));
    // floor of a tiny negative product
    send_op(make_op(CMD_PRODUCT, -32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0));
    send_op(make_op(CMD_PRODUCT, 32'sd1, 32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 32'sd1,
                    -32'sd1));
    send_op(make_op(CMD_PRODUCT, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, ONE, NEG_ONE,
                    ONE));
    send_op(make_op(CMD_ROTATE, 0, 0, 0, 0, W_MAX, ONE, ONE, ONE));
    send_op(make_op(CMD_ROTATE, ONE, 0, 0, 0, W_MIN, 32'sh0003_0000, -32'sh0002_0000, ONE));
    // quarter turn about z
    send_op(make_op(CMD_ROTATE, COS45, 0, 0, COS45, 0, ONE, 0, 0));
    // half turn about x
    send_op(make_op(CMD_ROTATE, 0, ONE, 0, 0, W_MAX, ONE, ONE, ONE));
    send_op(make_op(CMD_ROTATE, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    send_op(make_op(CMD_ROTATE, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    // conjugate of the most negative word
    send_op(make_op(CMD_ROTATE, 0, W_MIN, 0, 0, 0, W_MAX, 0, 0));
    send_op(make_op(CMD_ROTATE, ONE, 0, W_MIN, 0, 0, 0, 32'sd1, W_MIN));
    send_op(make_op(CMD_ROTATE, 32'sd1, 32'sd1, 32'sd1, W_MIN, 0, W_MIN, W_MAX, 32'sd1));
    send_op(make_op(CMD_ROTATE, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                    -32'sd1, -32'sd1));
    wait_drained();
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(150);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 60;
    recv_stall_pct = 0;
    send_random(130);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    send_random(130);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    send_random(150);
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 200;
    send_random(60);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input word_t exp_v, input word_t act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    quat_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        $error("result beat with no expected result");
        mismatch_count++;
      end else begin
        exp_r = expected_res.pop_front();
        check_field("res_w", exp_r.w, out_ch.res_w);
        check_field("res_x", exp_r.x, out_ch.res_x);
        check_field("res_y", exp_r.y, out_ch.res_y);
        check_field("res_z", exp_r.z, out_ch.res_z);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("quaternion_multiply_rotate_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    out_ch.ready  = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_PRODUCT;
    in_ch.a_w     = '0;
    in_ch.a_x     = '0;
    in_ch.a_y     = '0;
    in_ch.a_z     = '0;
    in_ch.b_w     = '0;
    in_ch.b_x     = '0;
    in_ch.b_y     = '0;
    in_ch.b_z     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold_off();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_res.size() == 0) begin
      $display("quaternion_multiply_rotate_tb OK");
    end else begin
      $display("quaternion_multiply_rotate_tb NOT OK");
    end
    $finish;
  end

endmodule
